/* src/smalu_pkg.sv */
// shared types and constants for the sign-magnitude alu
// word layouts, operation and status codes; no dependencies
`default_nettype none

package smalu_pkg;

  // operand and result words are 16 bits, top bit is the sign
  localparam int WIDTH = 16;
  localparam int MAG_W = WIDTH - 1;
  // shared adder: magnitude plus one carry bit and one sign bit
  localparam int ALU_W = MAG_W + 2;
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [WIDTH-1:0] operand_a;
    logic [WIDTH-1:0] operand_b;
  } alu_cmd_t;

  typedef struct packed {
    logic [WIDTH-1:0] result;
    logic [1:0]       status;
  } alu_res_t;

endpackage

`default_nettype wire

/* src/sign_magnitude_alu_core.sv */
// sign-magnitude alu core: add, subtract, multiply, divide
// one shared adder/subtractor under a small sequencer; uses smalu_pkg
`default_nettype none

// A command word (func, operand_a, operand_b) is taken on a clock edge where
// start is high and busy is low. Operands are sign-magnitude: bit 15 is the
// sign, bits 14..0 the magnitude; a negative zero counts as zero. Exactly one
// result word follows, shown on res for the single cycle in which done is
// high; the receiver must take it then, as it cannot hold the block off.
// All arithmetic runs through one 17-bit adder/subtractor. Add and subtract
// run one adder pass in S_ADD, and a second in S_NEG when the signs differ
// and the second magnitude is the larger (the difference is then taken the
// other way round), with done in the cycle after the last pass. Multiply and
// divide take one shift-add or restoring shift-subtract step per magnitude
// bit, with done after the last step; a zero divisor ends in the first step.
// busy drops in the cycle that carries done, so a new command may be taken
// alongside a result. Overflow and divide by zero give status 1 and 2 with a
// result of 0; a zero result is always positive.
module sign_magnitude_alu_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  smalu_pkg::alu_cmd_t cmd,
  output logic                done,
  output smalu_pkg::alu_res_t res
);
  import smalu_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;  // add, or first try at a - b
  localparam logic [2:0] S_NEG  = 3'd2;  // difference taken as b - a
  localparam logic [2:0] S_MUL  = 3'd3;  // one shift-add per step
  localparam logic [2:0] S_DIV  = 3'd4;  // one shift-subtract per step

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic             sign_a;   // sign of a, or of the product/quotient
  logic             sign_b;   // effective sign of b for add/subtract
  logic [MAG_W-1:0] acc;      // magnitude of a, product sum or remainder
  logic [MAG_W-1:0] yop;      // addend: mag a for multiply, mag b otherwise
  logic [MAG_W-1:0] shreg;    // bits scanned msb first
  logic [MAG_W-1:0] quo;
  logic             ovf;      // sticky product overflow

  // shared unit
  logic [ALU_W-1:0] unit_x;
  logic [ALU_W-1:0] unit_y;
  logic             unit_sub;
  logic [ALU_W-1:0] unit_sum;

  logic             ovf_next;
  logic             qbit;
  logic [MAG_W-1:0] quo_next;

  function automatic logic [WIDTH-1:0] pack_sm(input logic neg, input logic [MAG_W-1:0] mag);
    pack_sm = (mag == '0) ? '0 : {neg, mag};
  endfunction

  assign busy = (state != S_IDLE);

  always_comb begin
    unit_x   = '0;
    unit_y   = '0;
    unit_sub = 1'b0;
    unique case (state)
      S_ADD: begin
        unit_x   = {2'b00, acc};
        unit_y   = {2'b00, yop};
        unit_sub = (sign_a != sign_b);
      end
      S_NEG: begin
        unit_x   = {2'b00, yop};
        unit_y   = {2'b00, acc};
        unit_sub = 1'b1;
      end
      S_MUL: begin
        unit_x = {1'b0, acc, 1'b0};
        unit_y = shreg[MAG_W-1] ? {2'b00, yop} : '0;
      end
      S_DIV: begin
        unit_x   = {1'b0, acc, shreg[MAG_W-1]};
        unit_y   = {2'b00, yop};
        unit_sub = 1'b1;
      end
      default: begin
        unit_sub = 1'b0;
      end
    endcase
    unit_sum = unit_x + (unit_sub ? ~unit_y : unit_y) + ALU_W'(unit_sub);
  end

  assign ovf_next = ovf | (unit_sum[ALU_W-1:MAG_W] != '0);
  assign qbit     = ~unit_sum[ALU_W-1];
  assign quo_next = {quo[MAG_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cnt <= '0;
            ovf <= 1'b0;
            quo <= '0;
            unique case (cmd.func)
              FN_ADD, FN_SUB: begin
                state  <= S_ADD;
                acc    <= cmd.operand_a[MAG_W-1:0];
                yop    <= cmd.operand_b[MAG_W-1:0];
                sign_a <= cmd.operand_a[WIDTH-1];
                sign_b <= cmd.operand_b[WIDTH-1] ^ (cmd.func == FN_SUB);
              end
              FN_MUL: begin
                state  <= S_MUL;
                acc    <= '0;
                yop    <= cmd.operand_a[MAG_W-1:0];
                shreg  <= cmd.operand_b[MAG_W-1:0];
                sign_a <= cmd.operand_a[WIDTH-1] ^ cmd.operand_b[WIDTH-1];
              end
              default: begin
                state  <= S_DIV;
                acc    <= '0;
                yop    <= cmd.operand_b[MAG_W-1:0];
                shreg  <= cmd.operand_a[MAG_W-1:0];
                sign_a <= cmd.operand_a[WIDTH-1] ^ cmd.operand_b[WIDTH-1];
              end
            endcase
          end
        end
        S_ADD: begin
          if (!unit_sub) begin
            // same signs: carry into bit 15 means the magnitude overflowed
            done  <= 1'b1;
            state <= S_IDLE;
            if (unit_sum[MAG_W]) begin
              res.result <= '0;
              res.status <= ST_OVF;
            end else begin
              res.result <= pack_sm(sign_a, unit_sum[MAG_W-1:0]);
              res.status <= ST_OK;
            end
          end else if (unit_sum[ALU_W-1]) begin
            // a smaller than b: redo as b - a
            state <= S_NEG;
          end else begin
            done       <= 1'b1;
            state      <= S_IDLE;
            res.result <= pack_sm(sign_a, unit_sum[MAG_W-1:0]);
            res.status <= ST_OK;
          end
        end
        S_NEG: begin
          done       <= 1'b1;
          state      <= S_IDLE;
          res.result <= pack_sm(sign_b, unit_sum[MAG_W-1:0]);
          res.status <= ST_OK;
        end
        S_MUL: begin
          acc   <= unit_sum[MAG_W-1:0];
          ovf   <= ovf_next;
          shreg <= {shreg[MAG_W-2:0], 1'b0};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (ovf_next) begin
              res.result <= '0;
              res.status <= ST_OVF;
            end else begin
              res.result <= pack_sm(sign_a, unit_sum[MAG_W-1:0]);
              res.status <= ST_OK;
            end
          end
        end
        S_DIV: begin
          if (yop == '0) begin
            done       <= 1'b1;
            state      <= S_IDLE;
            res.result <= '0;
            res.status <= ST_DIVZ;
          end else begin
            // restoring step: keep the difference only when it is not negative
            acc   <= qbit ? unit_sum[MAG_W-1:0] : unit_x[MAG_W-1:0];
            quo   <= quo_next;
            shreg <= {shreg[MAG_W-2:0], 1'b0};
            cnt   <= cnt + 1'b1;
            if (cnt == CNT_LAST) begin
              done       <= 1'b1;
              state      <= S_IDLE;
              res.result <= pack_sm(sign_a, quo_next);
              res.status <= ST_OK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result word only appears as the sequencer hands back control
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");

  // an accepted command always makes the sequencer busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer stayed idle");

  // error status carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_OK) |-> (res.result == '0))
    else $error("non-zero result with error status");

  // no negative zero on the output
  a_no_negzero: assert property (@(posedge clk) disable iff (rst)
    (done && res.result[WIDTH-1]) |-> (res.result[MAG_W-1:0] != '0))
    else $error("negative zero result");

endmodule

`default_nettype wire
